// ----- src/tmse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the turing machine step engine
// no dependencies; used by every module of the block

package tmse_pkg;

    // default sizes, handed to the top level parameters
    localparam int NUM_STATES_DEF = 64;
    localparam int TAPE_LEN_DEF   = 64;

    // fixed field widths
    localparam int SYM_W   = 8;
    localparam int STATE_W = 6;
    localparam int POS_W   = 6;
    localparam int ACT_W   = 3;
    localparam int STAT_W  = 2;

    // symbol that fills the tape after reset
    localparam logic [SYM_W-1:0] BLANK_SYMBOL = 8'd124;

    // action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD    = 3'd0,
        ACT_ACCEPT  = 3'd1,
        ACT_REJECT  = 3'd2,
        ACT_WRITE   = 3'd3,
        ACT_STEP    = 3'd4,
        ACT_READ    = 3'd5,
        ACT_RESTART = 3'd6
    } action_t;

    // status codes
    localparam logic [STAT_W-1:0] STAT_RUN    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ACCEPT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FAULT  = 2'd3;

    // one transition table entry
    typedef struct packed {
        logic               valid;
        logic               right;
        logic [STATE_W-1:0] goto_state;
        logic [SYM_W-1:0]   symbol;
    } entry_t;

    // memory strobes from the controller
    typedef struct packed {
        logic tape_we;
        logic head_re;
        logic cell_re;
        logic table_we;
        logic table_re;
        logic mark_re;
        logic accept_we;
        logic reject_we;
    } mem_ctl_t;

    // controller states
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_RD_TAPE,
        ST_RD_RULE,
        ST_EVAL
    } fsm_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ----- src/tmse_tape.sv -----
`timescale 1ns / 1ps
`default_nettype none
// tape memory: one write port, a head read port and a cell read port
// depends on tmse_pkg

module tmse_tape #(
    parameter int  TAPE_LEN = tmse_pkg::TAPE_LEN_DEF,
    localparam int HW       = $clog2(TAPE_LEN)
) (
    input  wire logic                      clk,
    input  wire tmse_pkg::mem_ctl_t        ctl,
    input  wire logic [HW-1:0]             wr_addr,
    input  wire logic [tmse_pkg::SYM_W-1:0] wr_data,
    input  wire logic [HW-1:0]             head_addr,
    input  wire logic [HW-1:0]             cell_addr,
    output logic      [tmse_pkg::SYM_W-1:0] head_data,
    output logic      [tmse_pkg::SYM_W-1:0] cell_data
);

    logic [tmse_pkg::SYM_W-1:0] cells [TAPE_LEN];

    // synchronous write and registered reads
    always_ff @(posedge clk)
    begin
        if (ctl.tape_we)
        begin
            cells[wr_addr] <= wr_data;
        end
        if (ctl.head_re)
        begin
            head_data <= cells[head_addr];
        end
        if (ctl.cell_re)
        begin
            cell_data <= cells[cell_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/tmse_rules.sv -----
`timescale 1ns / 1ps
`default_nettype none
// transition table memory and accept / reject mark memories
// depends on tmse_pkg

module tmse_rules #(
    parameter int  NUM_STATES = tmse_pkg::NUM_STATES_DEF,
    localparam int SW         = $clog2(NUM_STATES),
    localparam int TAW        = SW + tmse_pkg::SYM_W
) (
    input  wire logic               clk,
    input  wire tmse_pkg::mem_ctl_t ctl,
    input  wire logic [TAW-1:0]     table_wr_addr,
    input  wire tmse_pkg::entry_t   table_wr_data,
    input  wire logic [TAW-1:0]     table_rd_addr,
    output tmse_pkg::entry_t        table_rd_data,
    input  wire logic [SW-1:0]      mark_wr_addr,
    input  wire logic               mark_wr_bit,
    input  wire logic [SW-1:0]      mark_rd_addr,
    output logic                    accept_data,
    output logic                    reject_data
);

    localparam int TABLE_DEPTH = NUM_STATES * 256;

    tmse_pkg::entry_t table_mem  [TABLE_DEPTH];
    logic             accept_mem [NUM_STATES];
    logic             reject_mem [NUM_STATES];

    // transition table, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (ctl.table_we)
        begin
            table_mem[table_wr_addr] <= table_wr_data;
        end
        if (ctl.table_re)
        begin
            table_rd_data <= table_mem[table_rd_addr];
        end
    end

    // accept and reject marks share address ports
    always_ff @(posedge clk)
    begin
        if (ctl.accept_we)
        begin
            accept_mem[mark_wr_addr] <= mark_wr_bit;
        end
        if (ctl.reject_we)
        begin
            reject_mem[mark_wr_addr] <= mark_wr_bit;
        end
        if (ctl.mark_re)
        begin
            accept_data <= accept_mem[mark_rd_addr];
            reject_data <= reject_mem[mark_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/tmse_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// sequencer: reset sweep, item decode, read-modify-write of tape and table,
// machine registers and the result register; depends on tmse_pkg

module tmse_ctrl #(
    parameter int  NUM_STATES = tmse_pkg::NUM_STATES_DEF,
    parameter int  TAPE_LEN   = tmse_pkg::TAPE_LEN_DEF,
    localparam int SW         = $clog2(NUM_STATES),
    localparam int HW         = $clog2(TAPE_LEN),
    localparam int TAW        = SW + tmse_pkg::SYM_W
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // item channel
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic [tmse_pkg::ACT_W-1:0]   action,
    input  wire logic [tmse_pkg::STATE_W-1:0] state_id,
    input  wire logic [tmse_pkg::SYM_W-1:0]   read_symbol,
    input  wire logic [tmse_pkg::SYM_W-1:0]   write_symbol,
    input  wire logic                         move_right,
    input  wire logic [tmse_pkg::STATE_W-1:0] next_state,
    input  wire logic [tmse_pkg::POS_W-1:0]   cell_index,
    input  wire logic [tmse_pkg::SYM_W-1:0]   cell_symbol,
    // result channel
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic      [tmse_pkg::STAT_W-1:0]  status,
    output logic      [tmse_pkg::STATE_W-1:0] current_state,
    output logic      [tmse_pkg::POS_W-1:0]   head_pos,
    output logic      [tmse_pkg::SYM_W-1:0]   symbol_out,
    output logic                              tape_changed,
    // memory side
    output tmse_pkg::mem_ctl_t                ctl,
    output logic      [HW-1:0]                tape_wr_addr,
    output logic      [tmse_pkg::SYM_W-1:0]   tape_wr_data,
    output logic      [HW-1:0]                head_addr,
    output logic      [HW-1:0]                cell_addr,
    input  wire logic [tmse_pkg::SYM_W-1:0]   head_data,
    input  wire logic [tmse_pkg::SYM_W-1:0]   cell_data,
    output logic      [TAW-1:0]               table_wr_addr,
    output tmse_pkg::entry_t                  table_wr_data,
    output logic      [TAW-1:0]               table_rd_addr,
    input  wire tmse_pkg::entry_t             table_rd_data,
    output logic      [SW-1:0]                mark_wr_addr,
    output logic                              mark_wr_bit,
    output logic      [SW-1:0]                mark_rd_addr,
    input  wire logic                         accept_data,
    input  wire logic                         reject_data
);

    localparam int TABLE_DEPTH = NUM_STATES * 256;
    localparam int SWEEP_LEN   = tmse_pkg::max_int(TABLE_DEPTH, TAPE_LEN);
    localparam int CW          = $clog2(SWEEP_LEN);

    // control registers
    tmse_pkg::fsm_t               fsm_reg, fsm_next;
    logic [CW-1:0]                sweep_cnt_reg, sweep_cnt_next;
    logic [tmse_pkg::STATE_W-1:0] mstate_reg, mstate_next;
    logic [HW-1:0]                head_reg, head_next;
    logic                         fault_reg, fault_next;
    logic                         out_valid_reg, out_valid_next;

    // item and result payload registers
    logic [tmse_pkg::ACT_W-1:0]   action_reg, action_next;
    logic [tmse_pkg::POS_W-1:0]   cidx_reg, cidx_next;
    logic                         cell_ok_reg, cell_ok_next;
    logic                         stepped_reg, stepped_next;
    logic [tmse_pkg::SYM_W-1:0]   sym_pend_reg, sym_pend_next;
    logic                         changed_reg, changed_next;
    logic [tmse_pkg::STAT_W-1:0]  out_status_reg, out_status_next;
    logic [tmse_pkg::STATE_W-1:0] out_state_reg, out_state_next;
    logic [tmse_pkg::POS_W-1:0]   out_head_reg, out_head_next;
    logic [tmse_pkg::SYM_W-1:0]   out_sym_reg, out_sym_next;
    logic                         out_changed_reg, out_changed_next;

    logic                         accept_item;
    logic                         sid_ok;
    logic                         nst_ok;
    logic                         cidx_ok;
    logic                         sweep_last;
    logic                         out_free;
    logic                         do_step;
    logic [tmse_pkg::STAT_W-1:0]  status_pre;

    // handshake and range checks
    assign item_stall  = (fsm_reg != tmse_pkg::ST_IDLE);
    assign accept_item = item_valid && !item_stall;
    assign sid_ok      = (32'(state_id) < 32'(NUM_STATES));
    assign nst_ok      = (32'(next_state) < 32'(NUM_STATES));
    assign cidx_ok     = (32'(cell_index) < 32'(TAPE_LEN));
    assign sweep_last  = (32'(sweep_cnt_reg) == 32'(SWEEP_LEN - 1));
    assign out_free    = !out_valid_reg || !result_stall;

    // status from the fault flag and the freshly read marks and table entry
    always_comb
    begin
        if (fault_reg)
        begin
            status_pre = tmse_pkg::STAT_FAULT;
        end
        else if (accept_data)
        begin
            status_pre = tmse_pkg::STAT_ACCEPT;
        end
        else if (reject_data || !table_rd_data.valid)
        begin
            status_pre = tmse_pkg::STAT_REJECT;
        end
        else
        begin
            status_pre = tmse_pkg::STAT_RUN;
        end
    end

    assign do_step = (fsm_reg == tmse_pkg::ST_EVAL)
                  && (action_reg == tmse_pkg::ACT_STEP)
                  && !stepped_reg
                  && (status_pre == tmse_pkg::STAT_RUN);

    // next state
    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            tmse_pkg::ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    fsm_next = tmse_pkg::ST_IDLE;
                end
            end
            tmse_pkg::ST_IDLE:
            begin
                if (accept_item)
                begin
                    fsm_next = tmse_pkg::ST_RD_TAPE;
                end
            end
            tmse_pkg::ST_RD_TAPE:
            begin
                fsm_next = tmse_pkg::ST_RD_RULE;
            end
            tmse_pkg::ST_RD_RULE:
            begin
                fsm_next = tmse_pkg::ST_EVAL;
            end
            tmse_pkg::ST_EVAL:
            begin
                if (do_step)
                begin
                    fsm_next = tmse_pkg::ST_RD_TAPE;
                end
                else if (out_free)
                begin
                    fsm_next = tmse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = tmse_pkg::ST_IDLE;
            end
        endcase
    end

    // memory strobes, addresses and write data
    always_comb
    begin
        ctl           = '0;
        tape_wr_addr  = head_reg;
        tape_wr_data  = table_rd_data.symbol;
        head_addr     = head_reg;
        cell_addr     = HW'(cidx_reg);
        table_wr_addr = {SW'(state_id), read_symbol};
        table_wr_data = '{valid: 1'b1, right: move_right,
                          goto_state: next_state, symbol: write_symbol};
        table_rd_addr = {SW'(mstate_reg), head_data};
        mark_wr_addr  = SW'(state_id);
        mark_wr_bit   = 1'b1;
        mark_rd_addr  = SW'(mstate_reg);
        case (fsm_reg)
            tmse_pkg::ST_SWEEP:
            begin
                ctl.tape_we   = (32'(sweep_cnt_reg) < 32'(TAPE_LEN));
                ctl.table_we  = (32'(sweep_cnt_reg) < 32'(TABLE_DEPTH));
                ctl.accept_we = (32'(sweep_cnt_reg) < 32'(NUM_STATES));
                ctl.reject_we = (32'(sweep_cnt_reg) < 32'(NUM_STATES));
                tape_wr_addr  = sweep_cnt_reg[HW-1:0];
                tape_wr_data  = tmse_pkg::BLANK_SYMBOL;
                table_wr_addr = sweep_cnt_reg[TAW-1:0];
                table_wr_data = '0;
                mark_wr_addr  = sweep_cnt_reg[SW-1:0];
                mark_wr_bit   = 1'b0;
            end
            tmse_pkg::ST_IDLE:
            begin
                if (accept_item)
                begin
                    case (action)
                        tmse_pkg::ACT_LOAD:
                        begin
                            ctl.table_we = sid_ok && nst_ok;
                        end
                        tmse_pkg::ACT_ACCEPT:
                        begin
                            ctl.accept_we = sid_ok;
                        end
                        tmse_pkg::ACT_REJECT:
                        begin
                            ctl.reject_we = sid_ok;
                        end
                        tmse_pkg::ACT_WRITE:
                        begin
                            ctl.tape_we  = cidx_ok;
                            tape_wr_addr = HW'(cell_index);
                            tape_wr_data = cell_symbol;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tmse_pkg::ST_RD_TAPE:
            begin
                ctl.head_re = 1'b1;
                ctl.cell_re = 1'b1;
                ctl.mark_re = 1'b1;
            end
            tmse_pkg::ST_RD_RULE:
            begin
                ctl.table_re = 1'b1;
            end
            tmse_pkg::ST_EVAL:
            begin
                ctl.tape_we = do_step;
            end
            default:
            begin
            end
        endcase
    end

    // machine registers, item capture and result register
    always_comb
    begin
        sweep_cnt_next   = sweep_cnt_reg;
        mstate_next      = mstate_reg;
        head_next        = head_reg;
        fault_next       = fault_reg;
        out_valid_next   = out_valid_reg && result_stall;
        action_next      = action_reg;
        cidx_next        = cidx_reg;
        cell_ok_next     = cell_ok_reg;
        stepped_next     = stepped_reg;
        sym_pend_next    = sym_pend_reg;
        changed_next     = changed_reg;
        out_status_next  = out_status_reg;
        out_state_next   = out_state_reg;
        out_head_next    = out_head_reg;
        out_sym_next     = out_sym_reg;
        out_changed_next = out_changed_reg;
        case (fsm_reg)
            tmse_pkg::ST_SWEEP:
            begin
                sweep_cnt_next = sweep_cnt_reg + CW'(1);
            end
            tmse_pkg::ST_IDLE:
            begin
                if (accept_item)
                begin
                    action_next   = action;
                    cidx_next     = cell_index;
                    cell_ok_next  = cidx_ok;
                    stepped_next  = 1'b0;
                    sym_pend_next = '0;
                    changed_next  = 1'b0;
                    if (action == tmse_pkg::ACT_RESTART)
                    begin
                        mstate_next = '0;
                        head_next   = '0;
                        fault_next  = 1'b0;
                    end
                end
            end
            tmse_pkg::ST_EVAL:
            begin
                if (do_step)
                begin
                    // write back, take the next state and move the head
                    sym_pend_next = table_rd_data.symbol;
                    changed_next  = (table_rd_data.symbol != head_data);
                    stepped_next  = 1'b1;
                    mstate_next   = table_rd_data.goto_state;
                    if (table_rd_data.right)
                    begin
                        if (32'(head_reg) + 32'd1 >= 32'(TAPE_LEN))
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            head_next = head_reg + HW'(1);
                        end
                    end
                    else
                    begin
                        if (head_reg == '0)
                        begin
                            fault_next = 1'b1;
                        end
                        else
                        begin
                            head_next = head_reg - HW'(1);
                        end
                    end
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_pre;
                    out_state_next  = mstate_reg;
                    out_head_next   = tmse_pkg::POS_W'(head_reg);
                    if (stepped_reg)
                    begin
                        out_sym_next = sym_pend_reg;
                    end
                    else if ((action_reg == tmse_pkg::ACT_READ) && cell_ok_reg)
                    begin
                        out_sym_next = cell_data;
                    end
                    else
                    begin
                        out_sym_next = '0;
                    end
                    out_changed_next = stepped_reg && changed_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= tmse_pkg::ST_SWEEP;
            sweep_cnt_reg <= '0;
            mstate_reg    <= '0;
            head_reg      <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            sweep_cnt_reg <= sweep_cnt_next;
            mstate_reg    <= mstate_next;
            head_reg      <= head_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        cidx_reg        <= cidx_next;
        cell_ok_reg     <= cell_ok_next;
        stepped_reg     <= stepped_next;
        sym_pend_reg    <= sym_pend_next;
        changed_reg     <= changed_next;
        out_status_reg  <= out_status_next;
        out_state_reg   <= out_state_next;
        out_head_reg    <= out_head_next;
        out_sym_reg     <= out_sym_next;
        out_changed_reg <= out_changed_next;
    end

    // result port
    assign result_valid  = out_valid_reg;
    assign status        = out_status_reg;
    assign current_state = out_state_reg;
    assign head_pos      = out_head_reg;
    assign symbol_out    = out_sym_reg;
    assign tape_changed  = out_changed_reg;

endmodule

`default_nettype wire

// ----- src/turing_machine_step_engine_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Results: a result is registered from EVAL after RD_TAPE and RD_RULE, and EVAL waits
//   while a stalled result is held; an executed step writes the cell back and reads tape,
//   marks and table again. Items: no new item is taken until the engine is idle again;
//   the chain of dependent reads (tape cell, then transition table) keeps it busy.
// Reset: asynchronous, active low; afterwards a clearing pass blanks tape, table and
//   marks with input stalled.

module turing_machine_step_engine_top #(
    parameter int NUM_STATES = tmse_pkg::NUM_STATES_DEF,
    parameter int TAPE_LEN   = tmse_pkg::TAPE_LEN_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic [tmse_pkg::ACT_W-1:0]   action,
    input  wire logic [tmse_pkg::STATE_W-1:0] state_id,
    input  wire logic [tmse_pkg::SYM_W-1:0]   read_symbol,
    input  wire logic [tmse_pkg::SYM_W-1:0]   write_symbol,
    input  wire logic                         move_right,
    input  wire logic [tmse_pkg::STATE_W-1:0] next_state,
    input  wire logic [tmse_pkg::POS_W-1:0]   cell_index,
    input  wire logic [tmse_pkg::SYM_W-1:0]   cell_symbol,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic      [tmse_pkg::STAT_W-1:0]  status,
    output logic      [tmse_pkg::STATE_W-1:0] current_state,
    output logic      [tmse_pkg::POS_W-1:0]   head_pos,
    output logic      [tmse_pkg::SYM_W-1:0]   symbol_out,
    output logic                              tape_changed
);

    localparam int SW  = $clog2(NUM_STATES);
    localparam int HW  = $clog2(TAPE_LEN);
    localparam int TAW = SW + tmse_pkg::SYM_W;

    tmse_pkg::mem_ctl_t         ctl;
    logic [HW-1:0]              tape_wr_addr;
    logic [tmse_pkg::SYM_W-1:0] tape_wr_data;
    logic [HW-1:0]              head_addr;
    logic [HW-1:0]              cell_addr;
    logic [tmse_pkg::SYM_W-1:0] head_data;
    logic [tmse_pkg::SYM_W-1:0] cell_data;
    logic [TAW-1:0]             table_wr_addr;
    tmse_pkg::entry_t           table_wr_data;
    logic [TAW-1:0]             table_rd_addr;
    tmse_pkg::entry_t           table_rd_data;
    logic [SW-1:0]              mark_wr_addr;
    logic                       mark_wr_bit;
    logic [SW-1:0]              mark_rd_addr;
    logic                       accept_data;
    logic                       reject_data;

    // sequencer
    tmse_ctrl #(
        .NUM_STATES (NUM_STATES),
        .TAPE_LEN   (TAPE_LEN)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .action        (action),
        .state_id      (state_id),
        .read_symbol   (read_symbol),
        .write_symbol  (write_symbol),
        .move_right    (move_right),
        .next_state    (next_state),
        .cell_index    (cell_index),
        .cell_symbol   (cell_symbol),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .current_state (current_state),
        .head_pos      (head_pos),
        .symbol_out    (symbol_out),
        .tape_changed  (tape_changed),
        .ctl           (ctl),
        .tape_wr_addr  (tape_wr_addr),
        .tape_wr_data  (tape_wr_data),
        .head_addr     (head_addr),
        .cell_addr     (cell_addr),
        .head_data     (head_data),
        .cell_data     (cell_data),
        .table_wr_addr (table_wr_addr),
        .table_wr_data (table_wr_data),
        .table_rd_addr (table_rd_addr),
        .table_rd_data (table_rd_data),
        .mark_wr_addr  (mark_wr_addr),
        .mark_wr_bit   (mark_wr_bit),
        .mark_rd_addr  (mark_rd_addr),
        .accept_data   (accept_data),
        .reject_data   (reject_data)
    );

    // tape memory
    tmse_tape #(
        .TAPE_LEN (TAPE_LEN)
    ) u_tape (
        .clk       (clk),
        .ctl       (ctl),
        .wr_addr   (tape_wr_addr),
        .wr_data   (tape_wr_data),
        .head_addr (head_addr),
        .cell_addr (cell_addr),
        .head_data (head_data),
        .cell_data (cell_data)
    );

    // transition table and marks
    tmse_rules #(
        .NUM_STATES (NUM_STATES)
    ) u_rules (
        .clk           (clk),
        .ctl           (ctl),
        .table_wr_addr (table_wr_addr),
        .table_wr_data (table_wr_data),
        .table_rd_addr (table_rd_addr),
        .table_rd_data (table_rd_data),
        .mark_wr_addr  (mark_wr_addr),
        .mark_wr_bit   (mark_wr_bit),
        .mark_rd_addr  (mark_rd_addr),
        .accept_data   (accept_data),
        .reject_data   (reject_data)
    );

endmodule

`default_nettype wire

// ----- src/tmse_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// port-level checks for the step engine, bound to the top level
// depends on tmse_pkg and turing_machine_step_engine_top

module tmse_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         item_valid,
    input wire logic                         item_stall,
    input wire logic                         result_valid,
    input wire logic                         result_stall,
    input wire logic [tmse_pkg::STAT_W-1:0]  status,
    input wire logic [tmse_pkg::STATE_W-1:0] current_state,
    input wire logic [tmse_pkg::POS_W-1:0]   head_pos,
    input wire logic [tmse_pkg::SYM_W-1:0]   symbol_out,
    input wire logic                         tape_changed
);

    // a stalled result stays and keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status)
            && $stable(current_state) && $stable(head_pos)
            && $stable(symbol_out) && $stable(tape_changed))
        else $error("stalled result changed");

    // the engine works on one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item taken while busy");

    // a new result only comes out of the read chain, never from idle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_stall) && $past(item_stall, 2))
        else $error("result without a finished read chain");

endmodule

bind turing_machine_step_engine_top tmse_checker u_checker (.*);

`default_nettype wire
